// ===== hdl/sgr_pkg.sv =====
// Shared types, constants and arithmetic helpers for the sparse Givens rotation block.
package sgr_pkg;

  // Field widths
  localparam int VALUE_W    = 16;
  localparam int COEF_W     = 16;
  localparam int INDEX_W    = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int COEF_FRAC  = 14;

  // Default store depth handed to the top level
  localparam int VECTOR_DEPTH_DEF = 1024;

  // Product and sum widths for the rotation datapath
  localparam int PROD_W = COEF_W + VALUE_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int QUO_W  = SUM_W - COEF_FRAC + 1;

  localparam logic signed [COEF_W-1:0] COEF_ONE   = COEF_W'(1 << COEF_FRAC);
  localparam logic signed [COEF_W-1:0] COS_RESET  = COEF_ONE;
  localparam logic signed [COEF_W-1:0] SIN_RESET  = '0;

  // Function codes
  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_ROTATE = 2'd1;
  localparam logic [1:0] FUNC_READ   = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COS  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SIN  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_BASE = CFG_IDX_W'(2);

  typedef struct packed {
    logic [1:0]                func;
    logic [INDEX_W-1:0]        element_index;
    logic signed [VALUE_W-1:0] element_value;
    logic                      last_element;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] result_value;
    logic                      status;
    logic                      last_out;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MUL,
    ST_SUM,
    ST_RND,
    ST_OUT
  } state_t;

  // How the latched request is handled
  typedef enum logic [1:0] {
    CLS_LOAD,
    CLS_READ,
    CLS_ROT,
    CLS_BYPASS
  } item_class_t;

  typedef struct packed {
    logic latch;
    logic ram_rd;
    logic wr_load;
    logic mul_en;
    logic sum_en;
    logic rnd_en;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    item_class_t cls;
  } dp_status_t;

  // Round to nearest (ties up) from Q.(14+f) to Q.f and saturate
  function automatic logic signed [VALUE_W-1:0] round_sat(input logic signed [SUM_W-1:0] acc);
    logic signed [SUM_W:0]   biased;
    logic signed [QUO_W-1:0] q;
    logic signed [QUO_W-1:0] sat_hi;
    logic signed [QUO_W-1:0] sat_lo;
    sat_hi = QUO_W'((64'sd1 <<< (VALUE_W - 1)) - 64'sd1);
    sat_lo = -sat_hi - QUO_W'(1);
    biased = (SUM_W+1)'(acc) + (SUM_W+1)'(1 << (COEF_FRAC - 1));
    q      = biased[SUM_W:COEF_FRAC];
    if (q > sat_hi) begin
      round_sat = sat_hi[VALUE_W-1:0];
    end else if (q < sat_lo) begin
      round_sat = sat_lo[VALUE_W-1:0];
    end else begin
      round_sat = q[VALUE_W-1:0];
    end
  endfunction

endpackage

// ===== hdl/sparse_givens_rotation.sv =====
// Top level of the sparse Givens rotation block: controller, datapath and checks.
//
// Applies a plane rotation (c, s in Q2.14) to sparse x elements against a dense y
// vector held in an on-chip store of VECTOR_DEPTH entries. Each request loads a y
// entry, reads one, or rotates one x element; each gives one result. Requests are
// handled one at a time by a state sequence: load, read, out-of-range and identity
// rotate requests pass from acceptance to the next acceptance through latch, decode
// with store access and result register; a real rotation adds the three steps of
// multiply, exact sum and round/saturate behind the store's registered read port.
// A new request is accepted while a finished result still waits in the output
// register. The store is not cleared at reset; an entry
// read before it is written returns an undefined value. Configuration writes are
// always taken and must only be issued while the block is idle.
module sparse_givens_rotation #(
  parameter int VECTOR_DEPTH = sgr_pkg::VECTOR_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  sgr_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output sgr_pkg::out_item_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sgr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sgr_pkg::COEF_W-1:0]    cfg_data
);

  sgr_pkg::ctrl_cmd_t  cmd;
  sgr_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  sgr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  sgr_datapath #(
    .VECTOR_DEPTH (VECTOR_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_item  (out_data)
  );

  // One request in flight: no acceptance right after an acceptance
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while previous one still in flight");

  // Store writes never happen while the block is idle
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_load || cmd.rnd_en) |-> !in_ready)
    else $error("store write while idle");

  // The result register is only loaded when free or being drained
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("pending result overwritten");

  // A result load always follows the request back to idle
  a_load_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> in_ready)
    else $error("controller did not return to idle after result");

endmodule

// ===== hdl/sgr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sgr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/sgr_ctrl.sv =====
// Sequencing state machine: steps one request through decode, multiply, sum and round (rotations only) and output.
module sgr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  sgr_pkg::dp_status_t status,
  output sgr_pkg::ctrl_cmd_t  cmd
);

  sgr_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;

  assign out_free = !out_valid_r || out_ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sgr_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = sgr_pkg::ST_DECODE;
      end
      sgr_pkg::ST_DECODE: begin
        if (status.cls == sgr_pkg::CLS_ROT) state_nxt = sgr_pkg::ST_MUL;
        else                                state_nxt = sgr_pkg::ST_OUT;
      end
      sgr_pkg::ST_MUL: state_nxt = sgr_pkg::ST_SUM;
      sgr_pkg::ST_SUM: state_nxt = sgr_pkg::ST_RND;
      sgr_pkg::ST_RND: state_nxt = sgr_pkg::ST_OUT;
      sgr_pkg::ST_OUT: begin
        if (out_free) state_nxt = sgr_pkg::ST_IDLE;
      end
      default: state_nxt = sgr_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      sgr_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      sgr_pkg::ST_DECODE: begin
        cmd.ram_rd  = (status.cls == sgr_pkg::CLS_READ) || (status.cls == sgr_pkg::CLS_ROT);
        cmd.wr_load = (status.cls == sgr_pkg::CLS_LOAD);
      end
      sgr_pkg::ST_MUL: cmd.mul_en = 1'b1;
      sgr_pkg::ST_SUM: cmd.sum_en = 1'b1;
      sgr_pkg::ST_RND: cmd.rnd_en = 1'b1;
      sgr_pkg::ST_OUT: cmd.out_load = out_free;
      default: cmd = '0;
    endcase
  end

  // Output valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load)    out_valid_nxt = 1'b1;
    else if (out_ready)  out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sgr_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== hdl/sgr_datapath.sv =====
// Datapath: config registers, request latch, dense store, rotation arithmetic, result register.
module sgr_datapath #(
  parameter int VECTOR_DEPTH = sgr_pkg::VECTOR_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  sgr_pkg::in_item_t               in_item,
  input  logic                            cfg_we,
  input  logic [sgr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sgr_pkg::COEF_W-1:0]      cfg_data,
  input  sgr_pkg::ctrl_cmd_t              cmd,
  output sgr_pkg::dp_status_t             status,
  output sgr_pkg::out_item_t              out_item
);

  localparam int AW = $clog2(VECTOR_DEPTH);

  logic signed [sgr_pkg::COEF_W-1:0]  cos_r, sin_r;
  logic                               base_r;
  sgr_pkg::in_item_t                  item_r;
  sgr_pkg::out_item_t                 out_item_r;
  sgr_pkg::item_class_t               cls;

  logic [sgr_pkg::INDEX_W-1:0]        pos, idx;
  logic                               pos_ok, rot_ok, identity;
  logic [AW-1:0]                      addr;
  logic signed [sgr_pkg::VALUE_W-1:0] xv, yv, ny, nx_r;
  logic [sgr_pkg::VALUE_W-1:0]        ram_rdata, ram_wdata;
  logic                               ram_we;

  logic signed [sgr_pkg::PROD_W-1:0]  cx_r, sy_r, cy_r, sx_r;
  logic signed [sgr_pkg::SUM_W-1:0]   sum_x_r, sum_y_r;

  logic signed [sgr_pkg::VALUE_W-1:0] byp_value;
  logic                               byp_status;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_r  <= sgr_pkg::COS_RESET;
      sin_r  <= sgr_pkg::SIN_RESET;
      base_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sgr_pkg::CFG_COS:  cos_r  <= cfg_data;
        sgr_pkg::CFG_SIN:  sin_r  <= cfg_data;
        sgr_pkg::CFG_BASE: base_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Request latch
  always_ff @(posedge clk) begin
    if (cmd.latch) item_r <= in_item;
  end

  // Index correction and range checks
  assign pos      = item_r.element_index;
  assign idx      = pos - sgr_pkg::INDEX_W'(base_r);
  assign pos_ok   = 32'(pos) < 32'(VECTOR_DEPTH);
  assign rot_ok   = !(base_r && (pos == '0)) && (32'(idx) < 32'(VECTOR_DEPTH));
  assign identity = (cos_r == sgr_pkg::COEF_ONE) && (sin_r == '0);
  assign xv       = item_r.element_value;

  // Request classification
  always_comb begin
    unique case (item_r.func)
      sgr_pkg::FUNC_LOAD:   cls = pos_ok ? sgr_pkg::CLS_LOAD : sgr_pkg::CLS_BYPASS;
      sgr_pkg::FUNC_READ:   cls = pos_ok ? sgr_pkg::CLS_READ : sgr_pkg::CLS_BYPASS;
      sgr_pkg::FUNC_ROTATE: cls = (rot_ok && !identity) ? sgr_pkg::CLS_ROT
                                                        : sgr_pkg::CLS_BYPASS;
      default:              cls = sgr_pkg::CLS_BYPASS;
    endcase
  end

  assign status.cls = cls;

  // Pass-through result: value echoed for load and rotate, zero otherwise
  always_comb begin
    byp_value  = '0;
    byp_status = 1'b1;
    case (item_r.func)
      sgr_pkg::FUNC_LOAD: byp_value = xv;
      sgr_pkg::FUNC_ROTATE: begin
        byp_value  = xv;
        byp_status = !rot_ok;
      end
      default: byp_value = '0;
    endcase
  end

  // Dense store
  assign addr      = (item_r.func == sgr_pkg::FUNC_ROTATE) ? AW'(idx) : AW'(pos);
  assign ram_we    = cmd.wr_load || cmd.rnd_en;
  assign ram_wdata = cmd.rnd_en ? ny : xv;

  sgr_ram #(
    .WIDTH (sgr_pkg::VALUE_W),
    .DEPTH (VECTOR_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (ram_wdata),
    .re    (cmd.ram_rd),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  assign yv = $signed(ram_rdata);

  // Products
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      cx_r <= cos_r * xv;
      sy_r <= sin_r * yv;
      cy_r <= cos_r * yv;
      sx_r <= sin_r * xv;
    end
  end

  // Exact sum and difference
  always_ff @(posedge clk) begin
    if (cmd.sum_en) begin
      sum_x_r <= sgr_pkg::SUM_W'(cx_r) + sgr_pkg::SUM_W'(sy_r);
      sum_y_r <= sgr_pkg::SUM_W'(cy_r) - sgr_pkg::SUM_W'(sx_r);
    end
  end

  // Round and saturate; new y goes straight into the store
  assign ny = sgr_pkg::round_sat(sum_y_r);

  always_ff @(posedge clk) begin
    if (cmd.rnd_en) nx_r <= sgr_pkg::round_sat(sum_x_r);
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_item_r.last_out <= item_r.last_element;
      case (cls)
        sgr_pkg::CLS_LOAD: begin
          out_item_r.result_value <= xv;
          out_item_r.status       <= 1'b0;
        end
        sgr_pkg::CLS_READ: begin
          out_item_r.result_value <= yv;
          out_item_r.status       <= 1'b0;
        end
        sgr_pkg::CLS_ROT: begin
          out_item_r.result_value <= nx_r;
          out_item_r.status       <= 1'b0;
        end
        default: begin
          out_item_r.result_value <= byp_value;
          out_item_r.status       <= byp_status;
        end
      endcase
    end
  end

  assign out_item = out_item_r;

endmodule
